// ----- rtl/core/lsf_pkg.sv -----
package lsf_pkg;

    // Fixed field widths of the transactions
    localparam int ByteWidth       = 8;
    localparam int KeptLengthWidth = 9;
    localparam int PlenWidth       = 6;
    localparam int PatternSlots    = 32;
    localparam int WordBytes       = 8;
    localparam int PatternWords    = PatternSlots / WordBytes;
    localparam int WordWidth       = WordBytes * ByteWidth;
    localparam int IndexWidth      = 3;

    localparam logic [ByteWidth-1:0]       NewlineChar  = 8'd10;
    localparam logic [KeptLengthWidth-1:0] KeptFieldMax = 9'h1FF;

    // Register indexes
    localparam logic [IndexWidth-1:0] RegPatternLength = 3'd0;
    localparam logic [IndexWidth-1:0] RegPatternWord0  = 3'd1;
    localparam logic [IndexWidth-1:0] RegPatternWord1  = 3'd2;
    localparam logic [IndexWidth-1:0] RegPatternWord2  = 3'd3;
    localparam logic [IndexWidth-1:0] RegPatternWord3  = 3'd4;

    typedef struct packed {
        logic [ByteWidth-1:0] text_byte;
        logic                 end_of_input;
    } item_t;

    typedef struct packed {
        logic                       line_matched;
        logic [KeptLengthWidth-1:0] kept_length;
        logic                       line_empty;
    } result_t;

    // Pattern as seen by the window compare: slot j holds pattern byte plen-1-j
    typedef struct packed {
        logic [PlenWidth-1:0]                    plen;
        logic [PatternSlots-1:0]                 slot_used;
        logic [PatternSlots-1:0][ByteWidth-1:0]  aligned;
    } match_cfg_t;

endpackage

// ----- rtl/core/lsf_cfg_regs.sv -----
module lsf_cfg_regs #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    write_enable,
    input  logic [lsf_pkg::IndexWidth-1:0]          register_index,
    input  logic [lsf_pkg::WordWidth-1:0]           write_data,
    output lsf_pkg::match_cfg_t                     match_cfg
);

    logic [lsf_pkg::PlenWidth-1:0]                                  plen_reg;
    logic [lsf_pkg::PatternWords-1:0][lsf_pkg::WordWidth-1:0]       pattern_reg;
    logic [lsf_pkg::PatternSlots-1:0][lsf_pkg::ByteWidth-1:0]       pattern_bytes;
    logic [lsf_pkg::PlenWidth-1:0]                                  plen_eff;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg    <= '0;
            pattern_reg <= '0;
        end
        else if (write_enable)
        begin
            case (register_index)
                lsf_pkg::RegPatternLength: plen_reg       <= write_data[lsf_pkg::PlenWidth-1:0];
                lsf_pkg::RegPatternWord0:  pattern_reg[0] <= write_data;
                lsf_pkg::RegPatternWord1:  pattern_reg[1] <= write_data;
                lsf_pkg::RegPatternWord2:  pattern_reg[2] <= write_data;
                lsf_pkg::RegPatternWord3:  pattern_reg[3] <= write_data;
                default:                   ;
            endcase
        end
    end

    assign pattern_bytes = pattern_reg;

    // Oversized lengths clamp to the window depth
    assign plen_eff = (plen_reg > lsf_pkg::PlenWidth'(PATTERN_MAX))
                    ? lsf_pkg::PlenWidth'(PATTERN_MAX) : plen_reg;

    // Reverse the pattern against the window: newest byte meets the last pattern byte.
    // Static between writes, so it sits off the per-byte path.
    always_comb
    begin
        logic [lsf_pkg::PlenWidth-1:0] idx;
        match_cfg.plen = plen_eff;
        for (int j = 0; j < lsf_pkg::PatternSlots; j++)
        begin
            idx = plen_eff - lsf_pkg::PlenWidth'(1) - lsf_pkg::PlenWidth'(j);
            match_cfg.slot_used[j] = lsf_pkg::PlenWidth'(j) < plen_eff;
            match_cfg.aligned[j]   = pattern_bytes[idx[4:0]];
        end
    end

    a_plen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        match_cfg.plen <= lsf_pkg::PlenWidth'(PATTERN_MAX))
        else $error("effective pattern length above window depth");

endmodule

// ----- rtl/core/lsf_line_engine.sv -----
module lsf_line_engine #(
    parameter int LINE_MAX    = 256,
    parameter int PATTERN_MAX = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  lsf_pkg::item_t       item,
    input  lsf_pkg::match_cfg_t  match_cfg,
    output lsf_pkg::result_t     result
);

    localparam int KW = $clog2(LINE_MAX + 1);
    localparam int CW = (KW > lsf_pkg::KeptLengthWidth) ? KW : lsf_pkg::KeptLengthWidth;
    localparam int SW = ((KW > lsf_pkg::PlenWidth) ? KW : lsf_pkg::PlenWidth) + 1;

    logic [PATTERN_MAX-1:0][lsf_pkg::ByteWidth-1:0] window_reg;
    logic [PATTERN_MAX-1:0][lsf_pkg::ByteWidth-1:0] window_next;
    logic [KW-1:0]  kept_reg;
    logic [KW-1:0]  kept_next;
    logic           any_seen_reg;
    logic           any_seen_next;
    logic           found_reg;
    logic           found_next;

    logic           closes;
    logic           kept_full;
    logic           keep_byte;
    logic           slots_equal;
    logic           enough_bytes;
    logic           hit;
    logic [CW-1:0]  kept_ext;

    assign closes    = item.end_of_input || (item.text_byte == lsf_pkg::NewlineChar);
    assign kept_full = kept_reg >= KW'(LINE_MAX);
    assign keep_byte = !closes && !kept_full;

    // Window after shifting in the current byte
    always_comb
    begin
        window_next[0] = item.text_byte;
        for (int j = 1; j < PATTERN_MAX; j++)
        begin
            window_next[j] = window_reg[j-1];
        end
    end

    // Parallel compare of every in-use slot
    always_comb
    begin
        slots_equal = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if (match_cfg.slot_used[j] && (window_next[j] != match_cfg.aligned[j]))
            begin
                slots_equal = 1'b0;
            end
        end
    end

    assign enough_bytes = (SW'(kept_reg) + SW'(1)) >= SW'(match_cfg.plen);
    assign hit = (match_cfg.plen == '0) || (enough_bytes && slots_equal);

    // Line state update
    always_comb
    begin
        kept_next     = kept_reg;
        any_seen_next = any_seen_reg;
        found_next    = found_reg;
        if (closes)
        begin
            kept_next     = '0;
            any_seen_next = 1'b0;
            found_next    = 1'b0;
        end
        else
        begin
            any_seen_next = 1'b1;
            if (keep_byte)
            begin
                kept_next = kept_reg + KW'(1);
                if (hit)
                begin
                    found_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg     <= '0;
            any_seen_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (advance)
        begin
            kept_reg     <= kept_next;
            any_seen_reg <= any_seen_next;
            found_reg    <= found_next;
        end
    end

    // Window is payload: only slots covered by the kept count are ever compared
    always_ff @(posedge clk)
    begin
        if (advance && keep_byte)
        begin
            window_reg <= window_next;
        end
    end

    // Result of the line closed by the current transaction
    assign kept_ext = CW'(kept_reg);
    assign result.line_matched = found_reg || (match_cfg.plen == '0);
    assign result.kept_length  = (kept_ext > CW'(lsf_pkg::KeptFieldMax))
                               ? lsf_pkg::KeptFieldMax
                               : kept_ext[lsf_pkg::KeptLengthWidth-1:0];
    assign result.line_empty   = !any_seen_reg;

    a_kept_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= KW'(LINE_MAX))
        else $error("kept count beyond line limit");

    a_found_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (any_seen_reg && kept_reg != '0))
        else $error("found flag set on a line with no kept byte");

endmodule

// ----- rtl/core/line_substring_filter.sv -----
// Channel | Direction | Handshake                 | Payload
// item    | in        | item_valid / item_stall   | lsf_pkg::item_t (text_byte, end_of_input)
// result  | out       | result_valid / result_stall | lsf_pkg::result_t
// config  | in        | write_enable              | register_index, write_data
//
// One byte per cycle while no line close is held at the output: a transaction is registered,
// then compared against the pattern window and folded into the line state as the stage advances.
// A line close passes the stage register, then raises result_valid from an output register.
// Reset (rst_n, asynchronous) clears the line state, the pattern and both stage valids.
// item_stall rises only when a line close waits behind a stalled, full result register.
module line_substring_filter #(
    parameter int LINE_MAX    = 256,
    parameter int PATTERN_MAX = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  lsf_pkg::item_t                 item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output lsf_pkg::result_t               result,
    input  logic                           write_enable,
    input  logic [lsf_pkg::IndexWidth-1:0] register_index,
    input  logic [lsf_pkg::WordWidth-1:0]  write_data
);

    lsf_pkg::match_cfg_t match_cfg;
    lsf_pkg::item_t      stage_item_reg;
    logic                stage_valid_reg;
    logic                stage_valid_next;
    lsf_pkg::result_t    engine_result;
    lsf_pkg::result_t    result_reg;
    logic                result_valid_reg;
    logic                result_valid_next;
    logic                stage_closes;
    logic                result_free;
    logic                stage_advance;
    logic                item_accept;

    lsf_cfg_regs #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .write_enable   (write_enable),
        .register_index (register_index),
        .write_data     (write_data),
        .match_cfg      (match_cfg)
    );

    lsf_line_engine #(
        .LINE_MAX    (LINE_MAX),
        .PATTERN_MAX (PATTERN_MAX)
    ) u_line_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (stage_advance),
        .item      (stage_item_reg),
        .match_cfg (match_cfg),
        .result    (engine_result)
    );

    // Stage handshake: plain bytes always move on, closes need room at the output
    assign stage_closes  = stage_item_reg.end_of_input
                        || (stage_item_reg.text_byte == lsf_pkg::NewlineChar);
    assign result_free   = !result_valid_reg || !result_stall;
    assign stage_advance = stage_valid_reg && (!stage_closes || result_free);
    assign item_stall    = stage_valid_reg && !stage_advance;
    assign item_accept   = item_valid && !item_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (item_accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (stage_advance && stage_closes)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            stage_item_reg <= item;
        end
        if (stage_advance && stage_closes)
        begin
            result_reg <= engine_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_stall_only_on_blocked_close: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (stage_valid_reg && stage_closes && result_valid_reg && result_stall))
        else $error("input stalled without a blocked line close");

    a_result_from_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(stage_advance && stage_closes))
        else $error("result raised without a line close");

    a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |-> !(stage_advance && stage_closes))
        else $error("line close overwrote a held result");

endmodule

// ----- verif/line_substring_filter_checker.sv -----
`timescale 1ns / 100ps

// Watches the item, result and register channels, predicts one result per
// closed line and compares each accepted result with the oldest prediction.
module line_substring_filter_checker
    import lsf_pkg::*;
#(
    parameter int LINE_MAX    = 256,
    parameter int PATTERN_MAX = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_stall,
    input  item_t                 item,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  result_t               result,
    input  logic                  write_enable,
    input  logic [IndexWidth-1:0] register_index,
    input  logic [WordWidth-1:0]  write_data,
    output int                    mismatches,
    output int                    lines_pending
);

    // Shadow copy of the pattern registers
    logic [PlenWidth-1:0] plen_reg;
    logic [WordWidth-1:0] pattern_word [PatternWords];

    // Line state: window[0] is the newest kept byte
    logic [ByteWidth-1:0] window [PATTERN_MAX];
    int                   kept;
    bit                   seen_byte;
    bit                   found;

    result_t predicted_lines[$];

    initial mismatches = 0;

    task automatic flag_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic [ByteWidth-1:0] pattern_char(input int k);
        return pattern_word[k / WordBytes][ByteWidth * (k % WordBytes) +: ByteWidth];
    endfunction

    // Newest 'act' window bytes against the pattern, pattern byte k at slot act-1-k
    function automatic bit window_holds_pattern();
        int act;
        act = (plen_reg > PATTERN_MAX) ? PATTERN_MAX : int'(plen_reg);
        if (act == 0)
            return 1'b1;
        if (kept < act)
            return 1'b0;
        for (int k = 0; k < act; k++)
        begin
            if (window[act - 1 - k] != pattern_char(k))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_line();
        for (int j = 0; j < PATTERN_MAX; j++)
            window[j] = '0;
        kept      = 0;
        seen_byte = 1'b0;
        found     = 1'b0;
    endtask

    task automatic take_char(input logic [ByteWidth-1:0] c);
        seen_byte = 1'b1;
        // bytes past LINE_MAX only mark the line as non-empty
        if (kept < LINE_MAX)
        begin
            for (int j = PATTERN_MAX - 1; j > 0; j--)
                window[j] = window[j - 1];
            window[0] = c;
            kept++;
            if (window_holds_pattern())
                found = 1'b1;
        end
    endtask

    task automatic close_line();
        result_t r;
        r.line_matched = found || (plen_reg == '0);
        r.kept_length  = (kept > KeptFieldMax) ? KeptFieldMax : KeptLengthWidth'(kept);
        r.line_empty   = !seen_byte;
        predicted_lines.push_back(r);
        clear_line();
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (predicted_lines.size() == 0)
        begin
            flag_mismatch("result transaction with no line pending");
            return;
        end
        want = predicted_lines.pop_front();
        if (got.line_matched !== want.line_matched)
            flag_mismatch($sformatf("line_matched got %0d, predicted %0d",
                                    got.line_matched, want.line_matched));
        if (got.kept_length !== want.kept_length)
            flag_mismatch($sformatf("kept_length got %0d, predicted %0d",
                                    got.kept_length, want.kept_length));
        if (got.line_empty !== want.line_empty)
            flag_mismatch($sformatf("line_empty got %0d, predicted %0d",
                                    got.line_empty, want.line_empty));
    endtask

    // Results are checked before the item of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg = '0;
            for (int w = 0; w < PatternWords; w++)
                pattern_word[w] = '0;
            clear_line();
            predicted_lines.delete();
            lines_pending = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result);
            if (item_valid && !item_stall)
            begin
                if (!item.end_of_input && item.text_byte != NewlineChar)
                    take_char(item.text_byte);
                else
                    close_line();
            end
            if (write_enable)
            begin
                case (register_index)
                    RegPatternLength: plen_reg        = write_data[PlenWidth-1:0];
                    RegPatternWord0:  pattern_word[0] = write_data;
                    RegPatternWord1:  pattern_word[1] = write_data;
                    RegPatternWord2:  pattern_word[2] = write_data;
                    RegPatternWord3:  pattern_word[3] = write_data;
                    default:          ;
                endcase
            end
            lines_pending = predicted_lines.size();
        end
    end

endmodule

// ----- verif/line_substring_filter_tb.sv -----
`timescale 1ns / 100ps

module line_substring_filter_tb;
    import lsf_pkg::*;

    localparam int LineMax    = 256;
    localparam int PatternMax = 32;
    localparam int TailCycles = 5;
    localparam int PhaseItems = 170;
    localparam int Phases     = 5;

    // Indexes above the last pattern word are ignored by the block
    localparam logic [IndexWidth-1:0] RegFirstUnused = RegPatternWord3 + 3'd1;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  item_valid     = 1'b0;
    logic                  item_stall;
    item_t                 item           = '0;
    logic                  result_valid;
    logic                  result_stall   = 1'b0;
    result_t               result;
    logic                  write_enable   = 1'b0;
    logic [IndexWidth-1:0] register_index = '0;
    logic [WordWidth-1:0]  write_data     = '0;

    int mismatches;
    int lines_pending;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int items_sent         = 0;

    // Stimulus copy of the pattern, used to build lines that hit it
    logic [ByteWidth-1:0] pattern_text [PatternSlots];
    int                   pattern_used = 0;

    line_substring_filter #(
        .LINE_MAX    (LineMax),
        .PATTERN_MAX (PatternMax)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .write_enable   (write_enable),
        .register_index (register_index),
        .write_data     (write_data)
    );

    line_substring_filter_checker #(
        .LINE_MAX    (LineMax),
        .PATTERN_MAX (PatternMax)
    ) line_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .write_enable   (write_enable),
        .register_index (register_index),
        .write_data     (write_data),
        .mismatches     (mismatches),
        .lines_pending  (lines_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < receiver_stall_pct);

    // Run limit
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [ByteWidth-1:0] any_char();
        logic [ByteWidth-1:0] c;
        do
            c = ByteWidth'($urandom_range(255));
        while (c == NewlineChar);
        return c;
    endfunction

    // Half the filler comes from the pattern alphabet to give partial hits
    function automatic logic [ByteWidth-1:0] filler_char();
        logic [ByteWidth-1:0] c;
        c = pattern_text[$urandom_range(PatternSlots - 1)];
        if ($urandom_range(1) == 0 || c == NewlineChar)
            c = any_char();
        return c;
    endfunction

    // One transaction on the item channel; valid stays high into the next call
    task automatic send_item(input logic [ByteWidth-1:0] b, input logic eoi);
        item_t nxt;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        nxt.text_byte    = b;
        nxt.end_of_input = eoi;
        item_valid <= 1'b1;
        item       <= nxt;
        do
            @(posedge clk);
        while (item_stall);
        items_sent++;
    endtask

    task automatic send_filler(input int n);
        repeat (n)
            send_item(filler_char(), 1'b0);
    endtask

    task automatic send_pattern_bytes(input int n);
        for (int k = 0; k < n; k++)
            send_item(pattern_text[k], 1'b0);
    endtask

    // Newline mostly, end of input otherwise with a random ignored byte
    task automatic end_line();
        if ($urandom_range(99) < 80)
            send_item(NewlineChar, 1'b0);
        else
            send_item(ByteWidth'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_random_line();
        int                   pick;
        int                   n;
        logic [ByteWidth-1:0] c;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            // pattern embedded in random text
            send_filler($urandom_range(12));
            send_pattern_bytes(pattern_used);
            send_filler($urandom_range(6));
        end
        else if (pick < 70)
        begin
            // near miss: truncated pattern or last byte altered
            send_filler($urandom_range(12));
            if (pattern_used > 1 && $urandom_range(1) == 0)
                send_pattern_bytes($urandom_range(1, pattern_used - 1));
            else if (pattern_used > 0)
            begin
                send_pattern_bytes(pattern_used - 1);
                c = pattern_text[pattern_used - 1] ^ 8'h80;
                if (c == NewlineChar)
                    c = c ^ 8'h03;
                send_item(c, 1'b0);
            end
        end
        else if (pick < 80)
        begin
            // empty line
        end
        else if (pick < 92)
        begin
            // noise over the full byte range, newlines included
            n = $urandom_range(15);
            repeat (n)
                send_item(ByteWidth'($urandom_range(255)), 1'b0);
        end
        else
            send_filler($urandom_range(1, 20));
        end_line();
    endtask

    // Line across the LINE_MAX boundary, pattern near the cut
    task automatic send_long_line();
        send_filler(LineMax - $urandom_range(pattern_used + 2));
        send_pattern_bytes(pattern_used);
        send_filler($urandom_range(6));
        end_line();
    endtask

    task automatic reg_write(input logic [IndexWidth-1:0] idx, input logic [WordWidth-1:0] d);
        write_enable   <= 1'b1;
        register_index <= idx;
        write_data     <= d;
        @(posedge clk);
    endtask

    task automatic randomise_pattern(input bit allow_newline);
        for (int k = 0; k < PatternSlots; k++)
            pattern_text[k] = allow_newline ? ByteWidth'($urandom_range(255)) : any_char();
    endtask

    // Writes pattern_text and the length, plus one write to an unused index
    task automatic program_pattern(input logic [PlenWidth-1:0] plen);
        logic [WordWidth-1:0] words [PatternWords];
        logic [WordWidth-1:0] len_word;
        for (int w = 0; w < PatternWords; w++)
            for (int b = 0; b < WordBytes; b++)
                words[w][ByteWidth * b +: ByteWidth] = pattern_text[WordBytes * w + b];
        len_word                = {$urandom, $urandom};
        len_word[PlenWidth-1:0] = plen;
        pattern_used = (plen > PatternMax) ? PatternMax : int'(plen);
        reg_write(RegFirstUnused + IndexWidth'($urandom_range(2)), {$urandom, $urandom});
        reg_write(RegPatternLength, len_word);
        reg_write(RegPatternWord0, words[0]);
        reg_write(RegPatternWord1, words[1]);
        reg_write(RegPatternWord2, words[2]);
        reg_write(RegPatternWord3, words[3]);
        write_enable <= 1'b0;
    endtask

    // Wait until every closed line has reported, then let the pipeline settle
    task automatic wait_drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (lines_pending != 0);
        repeat (TailCycles)
            @(posedge clk);
    endtask

    initial
    begin
        int phase_end;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset pattern is empty: every line matches, empty ones too
        send_item(NewlineChar, 1'b0);
        send_item(ByteWidth'($urandom_range(255)), 1'b1);
        send_item(8'h78, 1'b0);
        send_item(NewlineChar, 1'b0);
        wait_drain();

        // Short pattern holding a zero byte and 0xFF
        randomise_pattern(1'b0);
        pattern_text[0] = 8'h00;
        pattern_text[1] = 8'hFF;
        pattern_text[2] = 8'h41;
        program_pattern(6'd3);
        send_pattern_bytes(3);
        send_item(NewlineChar, 1'b0);
        send_pattern_bytes(2);
        send_item(NewlineChar, 1'b0);
        // window must not carry over a line break
        send_pattern_bytes(2);
        send_item(NewlineChar, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(NewlineChar, 1'b0);
        // end of input closes the line whatever its byte
        send_item(8'h41, 1'b0);
        send_pattern_bytes(3);
        send_item(NewlineChar, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'h41, 1'b1);

        // Random phases: one pattern setting and one idling mode each
        for (int phase = 0; phase < Phases; phase++)
        begin
            wait_drain();
            case (phase)
                0:
                begin
                    randomise_pattern(1'b0);
                    program_pattern(PlenWidth'($urandom_range(1, 4)));
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    randomise_pattern(1'b0);
                    program_pattern(6'd32);
                    sender_idle_pct    = 85;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    // oversized length, pattern may hold a newline
                    randomise_pattern(1'b1);
                    program_pattern(PlenWidth'($urandom_range(33, 63)));
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 85;
                end
                3:
                begin
                    randomise_pattern(1'b0);
                    program_pattern(6'd1);
                    sender_idle_pct    = 17;
                    receiver_stall_pct = 17;
                end
                default:
                begin
                    randomise_pattern(1'b1);
                    program_pattern(6'd0);
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            phase_end = items_sent + PhaseItems;
            if (phase == 1 || phase == 3)
                send_long_line();
            while (items_sent < phase_end)
                send_random_line();
        end
        send_item(ByteWidth'($urandom_range(255)), 1'b1);
        wait_drain();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
